// ===== rtl/hbed_pkg.sv =====
// Package for the Huffman build, encode and decode block.
// Holds sizes, the build sequencer states and the memory write request types.
// No dependencies.
package hbed_pkg;
	localparam int SYMBOLS     = 6;
	localparam int NODES       = 2 * SYMBOLS - 1;
	localparam int NODE_W      = $clog2(NODES + 1);
	localparam int SYM_W       = 3;
	localparam int WEIGHT_REGS = 6;
	localparam int WEIGHT_W    = 16;
	localparam int NWEIGHT_W   = 19;
	localparam int MAX_CODE    = 5;
	localparam int CODE_W      = 5;
	localparam int LEN_W       = 3;
	localparam int CFG_IDX_W   = 3;

	localparam logic [NODE_W-1:0] ROOT = NODE_W'(NODES);

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;
	localparam logic KIND_CODE   = 1'b0;
	localparam logic KIND_SYMBOL = 1'b1;

	typedef logic [WEIGHT_REGS-1:0][WEIGHT_W-1:0] weight_arr_t;

	typedef enum logic [2:0] {
		B_INIT,
		B_SCAN,
		B_MERGE,
		B_CODE,
		B_DONE
	} build_state_t;

	typedef struct packed {
		logic              en;
		logic [NODE_W-1:0] addr;
		logic [NODE_W-1:0] left;
		logic [NODE_W-1:0] right;
	} tree_wr_t;

	typedef struct packed {
		logic             en;
		logic [SYM_W-1:0] addr;
		logic [CODE_W-1:0] bits;
		logic [LEN_W-1:0] len;
	} code_wr_t;
endpackage

// ===== rtl/hbed_build.sv =====
// Tree and code table build sequencer: one scan step, merge or code walk step per cycle.
// Depends on hbed_pkg; feeds write requests to hbed_lookup.
module hbed_build (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                restart,
	input  hbed_pkg::weight_arr_t weights,
	output logic                tree_valid,
	output hbed_pkg::tree_wr_t  tree_wr,
	output hbed_pkg::code_wr_t  code_wr
);
	import hbed_pkg::*;

	build_state_t state_q, state_d;

	logic [NWEIGHT_W-1:0] w_q [1:NODES];
	logic [NODE_W-1:0]    par_q [1:NODES];
	logic [NODE_W-1:0]    lc_q [SYMBOLS+1:NODES];

	logic [NODE_W-1:0]    n_q, j_q, a_q, b_q, c_q;
	logic [NWEIGHT_W-1:0] wa_q, wb_q;
	logic [1:0]           found_q;
	logic [SYM_W-1:0]     s_q;
	logic [CODE_W-1:0]    bits_q;
	logic [LEN_W-1:0]     len_q;

	logic [NODE_W-1:0]    pidx, p;
	logic [NWEIGHT_W-1:0] wj;
	logic                 walk;
	logic                 scan_last, code_last, merge_last;

	assign pidx       = (state_q == B_CODE) ? c_q : j_q;
	assign p          = par_q[pidx];
	assign wj         = w_q[j_q];
	assign walk       = (p != '0) && (len_q < LEN_W'(MAX_CODE));
	assign scan_last  = (j_q == n_q - NODE_W'(1));
	assign merge_last = (n_q == ROOT);
	assign code_last  = (s_q == SYM_W'(SYMBOLS - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_INIT:  state_d = B_SCAN;
			B_SCAN:  if (scan_last) state_d = B_MERGE;
			B_MERGE: state_d = merge_last ? B_CODE : B_SCAN;
			B_CODE:  if (!walk && code_last) state_d = B_DONE;
			B_DONE:  state_d = B_DONE;
			default: state_d = B_INIT;
		endcase
		if (restart) state_d = B_INIT;
	end

	always_comb begin
		tree_valid    = (state_q == B_DONE);
		tree_wr.en    = (state_q == B_MERGE);
		tree_wr.addr  = n_q;
		tree_wr.left  = a_q;
		tree_wr.right = b_q;
		code_wr.en    = (state_q == B_CODE) && !walk;
		code_wr.addr  = s_q;
		code_wr.bits  = bits_q;
		code_wr.len   = len_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_INIT: begin
				for (int i = 1; i <= NODES; i++) par_q[i] <= '0;
				for (int i = 1; i <= SYMBOLS; i++) w_q[i] <= NWEIGHT_W'(weights[i-1]);
				n_q     <= NODE_W'(SYMBOLS + 1);
				j_q     <= NODE_W'(1);
				found_q <= 2'd0;
			end
			B_SCAN: begin
				if (par_q[j_q] == '0) begin
					case (found_q)
						2'd0: begin
							a_q     <= j_q;
							wa_q    <= wj;
							found_q <= 2'd1;
						end
						2'd1: begin
							found_q <= 2'd2;
							if (wa_q > wj) begin
								b_q  <= a_q;
								wb_q <= wa_q;
								a_q  <= j_q;
								wa_q <= wj;
							end else begin
								b_q  <= j_q;
								wb_q <= wj;
							end
						end
						default: begin
							if (wj < wa_q) begin
								b_q  <= a_q;
								wb_q <= wa_q;
								a_q  <= j_q;
								wa_q <= wj;
							end else if (wj < wb_q) begin
								b_q  <= j_q;
								wb_q <= wj;
							end
						end
					endcase
				end
				j_q <= j_q + NODE_W'(1);
			end
			B_MERGE: begin
				w_q[n_q]  <= wa_q + wb_q;
				par_q[a_q] <= n_q;
				par_q[b_q] <= n_q;
				lc_q[n_q] <= a_q;
				n_q       <= n_q + NODE_W'(1);
				j_q       <= NODE_W'(1);
				found_q   <= 2'd0;
				s_q       <= '0;
				c_q       <= NODE_W'(1);
				len_q     <= '0;
				bits_q    <= '0;
			end
			B_CODE: begin
				if (walk) begin
					if (lc_q[p] != c_q) bits_q <= bits_q | (CODE_W'(1) << len_q);
					len_q <= len_q + LEN_W'(1);
					c_q   <= p;
				end else begin
					s_q    <= s_q + SYM_W'(1);
					c_q    <= NODE_W'(s_q) + NODE_W'(2);
					len_q  <= '0;
					bits_q <= '0;
				end
			end
			default: begin
			end
		endcase
	end
endmodule

// ===== rtl/hbed_lookup.sv =====
// Tree and code table memories with the request stage, decode walker and output register.
// Depends on hbed_pkg; written by hbed_build.
module hbed_lookup (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     tree_valid,
	input  hbed_pkg::tree_wr_t       tree_wr,
	input  hbed_pkg::code_wr_t       code_wr,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     mode,
	input  logic [hbed_pkg::SYM_W-1:0] symbol_in,
	input  logic                     code_bit,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     result_kind,
	output logic [hbed_pkg::CODE_W-1:0] code_word,
	output logic [hbed_pkg::LEN_W-1:0]  code_length,
	output logic [hbed_pkg::SYM_W-1:0]  symbol_out
);
	import hbed_pkg::*;

	logic [2*NODE_W-1:0]      tree_mem [SYMBOLS+1:NODES];
	logic [CODE_W+LEN_W-1:0]  code_mem [0:SYMBOLS-1];
	logic [2*NODE_W-1:0]      tree_rd_s2;
	logic [CODE_W+LEN_W-1:0]  code_rd_s2;

	logic              s1_v_q, mode_s1, sym_ok_s1, bit_s1;
	logic [NODE_W-1:0] dnode_q, next_node;
	logic              accept, done, leaf;

	assign in_stall  = !tree_valid || s1_v_q;
	assign accept    = in_valid && !in_stall;
	assign done      = s1_v_q && (!out_valid || !out_stall);
	assign next_node = bit_s1 ? tree_rd_s2[NODE_W-1:0] : tree_rd_s2[2*NODE_W-1:NODE_W];
	assign leaf      = (next_node <= NODE_W'(SYMBOLS));

	always_ff @(posedge clk) begin
		if (tree_wr.en) tree_mem[tree_wr.addr] <= {tree_wr.left, tree_wr.right};
		if (code_wr.en) code_mem[code_wr.addr] <= {code_wr.bits, code_wr.len};
		if (accept) begin
			tree_rd_s2 <= tree_mem[dnode_q];
			if (symbol_in < SYM_W'(SYMBOLS)) code_rd_s2 <= code_mem[symbol_in];
			mode_s1   <= mode;
			sym_ok_s1 <= (symbol_in < SYM_W'(SYMBOLS));
			bit_s1    <= code_bit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q    <= 1'b0;
			dnode_q   <= ROOT;
			out_valid <= 1'b0;
		end else begin
			if (accept) s1_v_q <= 1'b1;
			else if (done) s1_v_q <= 1'b0;
			if (!tree_valid) begin
				dnode_q <= ROOT;
			end else if (done && mode_s1 == MODE_DECODE) begin
				dnode_q <= leaf ? ROOT : next_node;
			end
			if (done && (mode_s1 == MODE_DECODE ? leaf : sym_ok_s1)) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			if (mode_s1 == MODE_DECODE) begin
				result_kind <= KIND_SYMBOL;
				code_word   <= '0;
				code_length <= '0;
				symbol_out  <= SYM_W'(next_node - NODE_W'(1));
			end else begin
				result_kind <= KIND_CODE;
				code_word   <= code_rd_s2[CODE_W+LEN_W-1:LEN_W];
				code_length <= code_rd_s2[LEN_W-1:0];
				symbol_out  <= '0;
			end
		end
	end
endmodule

// ===== rtl/huffman_build_encode_decode_top.sv =====
// Top level of the static Huffman build, encode and decode block.
// Depends on hbed_pkg, hbed_build and hbed_lookup.
//
//   Channel   Direction  Handshake             Payload
//   in        to block   in_valid / in_stall   mode, symbol_in, code_bit
//   out       from block out_valid / out_stall result_kind, code_word, code_length, symbol_out
//   cfg       to block   cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each request is registered in a memory read stage; then the decode walker or code table
// result goes to the output register. No new request is taken while one sits in the read
// stage. After reset or a weight write the tree is rebuilt, and no request is taken until
// the build is done. A stalled output holds the next request in its read stage.
module huffman_build_encode_decode_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        mode,
	input  logic [hbed_pkg::SYM_W-1:0]  symbol_in,
	input  logic                        code_bit,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        result_kind,
	output logic [hbed_pkg::CODE_W-1:0] code_word,
	output logic [hbed_pkg::LEN_W-1:0]  code_length,
	output logic [hbed_pkg::SYM_W-1:0]  symbol_out,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [hbed_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hbed_pkg::WEIGHT_W-1:0]  cfg_data
);
	import hbed_pkg::*;

	weight_arr_t weights_q;
	logic        cfg_wr, weight_wr, tree_valid;
	tree_wr_t    tree_wr;
	code_wr_t    code_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign weight_wr = cfg_wr && (cfg_index < CFG_IDX_W'(WEIGHT_REGS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WEIGHT_REGS; i++) weights_q[i] <= WEIGHT_W'(1);
		end else if (weight_wr) begin
			weights_q[cfg_index] <= cfg_data;
		end
	end

	hbed_build u_build (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (weight_wr),
		.weights    (weights_q),
		.tree_valid (tree_valid),
		.tree_wr    (tree_wr),
		.code_wr    (code_wr)
	);

	hbed_lookup u_lookup (
		.clk         (clk),
		.arst_n      (arst_n),
		.tree_valid  (tree_valid),
		.tree_wr     (tree_wr),
		.code_wr     (code_wr),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.symbol_in   (symbol_in),
		.code_bit    (code_bit),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.code_word   (code_word),
		.code_length (code_length),
		.symbol_out  (symbol_out)
	);
endmodule

// ===== rtl/hbed_checker.sv =====
// Port level checks for the Huffman block, bound to the top level.
// Depends on hbed_pkg.
module hbed_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic                        result_kind,
	input logic [hbed_pkg::CODE_W-1:0] code_word,
	input logic [hbed_pkg::LEN_W-1:0]  code_length,
	input logic [hbed_pkg::SYM_W-1:0]  symbol_out
);
	import hbed_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("Stalled result dropped.");

	a_sym_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_SYMBOL |-> code_word == '0 && code_length == '0)
		else $error("Decoded result carries code bits.");

	a_code_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_CODE |-> symbol_out == '0)
		else $error("Code result carries a symbol.");

	a_sym_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_SYMBOL |-> symbol_out < SYM_W'(SYMBOLS))
		else $error("Decoded symbol out of range.");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_CODE |->
			code_length != '0 && code_length <= LEN_W'(MAX_CODE))
		else $error("Code length out of range.");
endmodule

bind huffman_build_encode_decode_top hbed_checker u_hbed_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.result_kind (result_kind),
	.code_word   (code_word),
	.code_length (code_length),
	.symbol_out  (symbol_out)
);
